// ===== hdl/flocking_steering_force_core_macros.svh =====
// ---------------------------------------------------------------------------
// Flocking steering force core: assertion macros
// Clocked implication checks, empty when synthesising.
// ---------------------------------------------------------------------------
`ifndef FLOCKING_STEERING_FORCE_CORE_MACROS_SVH
`define FLOCKING_STEERING_FORCE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define FSF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fsf: same-cycle check failed");
`define FSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fsf: next-cycle check failed");
`else
`define FSF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FSF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/fsf_pkg.sv =====
// ---------------------------------------------------------------------------
// Flocking steering force package
// Widths, operand selects, command/status bundles and saturation helpers.
// ---------------------------------------------------------------------------
package fsf_pkg;

    localparam int FIX_W    = 32;
    localparam int SUM_W    = 40;
    localparam int D_W      = 33;
    localparam int SQ_W     = 66;
    localparam int A_W      = 42;
    localparam int B_W      = 33;
    localparam int PART_W   = 22;
    localparam int LO_W     = 21;
    localparam int PP_W     = 55;
    localparam int PROD_W   = 75;
    localparam int TOT_W    = 62;
    localparam int MEAN_W   = 41;
    localparam int Q_W      = 40;
    localparam int NUM_W    = 64;
    localparam int CNT_OUT_W = 7;
    localparam int FRAC_W   = 16;
    localparam int DIV_SEP_BITS  = 33;
    localparam int DIV_MEAN_BITS = 40;
    localparam int DIV_CNT_W     = 6;

    localparam logic [2:0] REG_SEP_GAIN    = 3'd0;
    localparam logic [2:0] REG_COH_GAIN    = 3'd1;
    localparam logic [2:0] REG_ALI_GAIN    = 3'd2;
    localparam logic [2:0] REG_FOLLOW_GAIN = 3'd3;
    localparam logic [2:0] REG_GOAL_GAIN   = 3'd4;

    typedef enum logic [2:0] {
        MS_SQ  = 3'd0,
        MS_AUX = 3'd1,
        MS_SEP = 3'd2,
        MS_COH = 3'd3,
        MS_ALI = 3'd4
    } msel_t;

    typedef struct packed {
        logic [FIX_W-1:0] sep;
        logic [FIX_W-1:0] coh;
        logic [FIX_W-1:0] ali;
        logic [FIX_W-1:0] fol;
        logic [FIX_W-1:0] goal;
    } gains_t;

    typedef struct packed {
        logic       load;
        logic       mul_lo;
        logic       mul_hi;
        msel_t      msel;
        logic       sq_acc;
        logic       div_start;
        logic       div_mean;
        logic       sep_acc;
        logic       term_acc;
        logic       mean_set;
        logic       force_store;
        logic       out_load;
        logic [1:0] ax;
    } cmd_t;

    typedef struct packed {
        logic cnt_lt_max;
        logic cnt_zero;
        logic s_zero;
        logic div_done;
    } status_t;

    function automatic logic [SUM_W-1:0] sat40(input logic [SUM_W+1:0] v);
        logic [SUM_W-1:0] r;
        if (v[SUM_W+1:SUM_W-1] == 3'b000 || v[SUM_W+1:SUM_W-1] == 3'b111)
            r = v[SUM_W-1:0];
        else if (v[SUM_W+1])
            r = {1'b1, {(SUM_W-1){1'b0}}};
        else
            r = {1'b0, {(SUM_W-1){1'b1}}};
        return r;
    endfunction

    function automatic logic [FIX_W-1:0] sat32(input logic [TOT_W-1:0] v);
        logic [FIX_W-1:0] r;
        if ((&v[TOT_W-1:FIX_W-1]) || !(|v[TOT_W-1:FIX_W-1]))
            r = v[FIX_W-1:0];
        else if (v[TOT_W-1])
            r = {1'b1, {(FIX_W-1){1'b0}}};
        else
            r = {1'b0, {(FIX_W-1){1'b1}}};
        return r;
    endfunction

endpackage

// ===== hdl/fsf_div.sv =====
// ---------------------------------------------------------------------------
// Flocking steering force divider
// Restoring divider, one quotient bit per cycle, 33 or 40 bits per run.
// ---------------------------------------------------------------------------
module fsf_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      mean_mode,
    input  logic [fsf_pkg::NUM_W-1:0] dividend,
    input  logic [fsf_pkg::SQ_W-1:0]  divisor,
    output logic                      busy,
    output logic                      done,
    output logic [fsf_pkg::Q_W-1:0]   quot
);
    import fsf_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [SQ_W-1:0]      rem_reg, rem_next;
    logic [SQ_W-1:0]      den_reg, den_next;
    logic [NUM_W-1:0]     sh_reg, sh_next;
    logic [Q_W-1:0]       quot_reg, quot_next;
    logic [SQ_W:0]        trial;
    logic [SQ_W:0]        diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        sh_next   = sh_reg;
        quot_next = quot_reg;
        trial     = {rem_reg, sh_reg[NUM_W-1]};
        diff      = trial - {1'b0, den_reg};
        if (start)
        begin
            busy_next = 1'b1;
            den_next  = divisor;
            quot_next = '0;
            if (mean_mode)
            begin
                rem_next = SQ_W'(dividend >> DIV_MEAN_BITS);
                sh_next  = dividend << (NUM_W - DIV_MEAN_BITS);
                cnt_next = DIV_CNT_W'(DIV_MEAN_BITS);
            end
            else
            begin
                rem_next = SQ_W'(dividend >> DIV_SEP_BITS);
                sh_next  = dividend << (NUM_W - DIV_SEP_BITS);
                cnt_next = DIV_CNT_W'(DIV_SEP_BITS);
            end
        end
        else if (busy_reg)
        begin
            // keep the difference when the trial remainder covers the divisor
            if (!diff[SQ_W])
            begin
                rem_next  = diff[SQ_W-1:0];
                quot_next = {quot_reg[Q_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[SQ_W-1:0];
                quot_next = {quot_reg[Q_W-2:0], 1'b0};
            end
            sh_next  = {sh_reg[NUM_W-2:0], 1'b0};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        sh_reg   <= sh_next;
        quot_reg <= quot_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== hdl/fsf_dp.sv =====
// ---------------------------------------------------------------------------
// Flocking steering force datapath
// Agent state, accumulators, shared multiplier, divider and result register.
// ---------------------------------------------------------------------------
module fsf_dp #(
    parameter int MAX_NEIGHBOURS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fsf_pkg::cmd_t                       cmd,
    input  fsf_pkg::gains_t                     gains,
    input  logic                                in_kind,
    input  logic                                in_leader,
    input  logic [2:0][fsf_pkg::FIX_W-1:0]      in_pos,
    input  logic [2:0][fsf_pkg::FIX_W-1:0]      in_aux,
    output fsf_pkg::status_t                    status,
    output logic [2:0][fsf_pkg::FIX_W-1:0]      out_force,
    output logic [fsf_pkg::CNT_OUT_W-1:0]       out_count
);
    import fsf_pkg::*;

    localparam int CW = $clog2(MAX_NEIGHBOURS + 1);

    logic [FIX_W-1:0]  self_reg [3];
    logic [FIX_W-1:0]  goal_reg [3];
    logic              mode_reg;
    logic [SUM_W-1:0]  sep_reg  [3];
    logic [SUM_W-1:0]  ali_reg  [3];
    logic [SUM_W-1:0]  coh_reg  [3];
    logic [CW-1:0]     count_reg;
    logic [D_W-1:0]    d_reg    [3];
    logic [SQ_W-1:0]   s_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [TOT_W-1:0]  total_reg;
    logic [MEAN_W-1:0] mean_reg;
    logic [FIX_W-1:0]  force_reg [3];
    logic [2:0][FIX_W-1:0] out_force_reg;
    logic [CNT_OUT_W-1:0]  out_count_reg;

    logic [D_W-1:0]    d_sel;
    logic [FIX_W-1:0]  self_sel;
    logic [FIX_W-1:0]  goal_sel;
    logic [SUM_W-1:0]  sep_sel;
    logic [SUM_W-1:0]  sum_mean;
    logic [D_W-1:0]    aux_off;
    logic [FIX_W-1:0]  gain_aux;
    logic [A_W-1:0]    a_op;
    logic [B_W-1:0]    b_op;
    logic signed [PART_W-1:0] part;
    logic signed [PP_W-1:0]   pp;
    logic [PROD_W-1:0] prod_next;
    logic [SUM_W:0]    mean_abs;
    logic [D_W-1:0]    d_abs;
    logic [NUM_W-1:0]  div_dividend;
    logic [SQ_W-1:0]   div_divisor;
    logic              div_busy;
    logic              div_done;
    logic [Q_W-1:0]    quot;
    logic [MEAN_W-1:0] sep_val;
    logic [MEAN_W-1:0] mean_val;
    logic              cnt_lt_max;

    always_comb
    begin
        d_sel    = d_reg[cmd.ax];
        self_sel = self_reg[cmd.ax];
        goal_sel = goal_reg[cmd.ax];
        sep_sel  = sep_reg[cmd.ax];
        sum_mean = (cmd.msel == MS_COH) ? coh_reg[cmd.ax] : ali_reg[cmd.ax];
        aux_off  = {goal_sel[FIX_W-1], goal_sel} - {self_sel[FIX_W-1], self_sel};
        gain_aux = mode_reg ? gains.fol : gains.goal;

        case (cmd.msel)
            MS_SQ:
            begin
                a_op = {{(A_W-D_W){d_sel[D_W-1]}}, d_sel};
                b_op = d_sel;
            end
            MS_AUX:
            begin
                a_op = {{(A_W-D_W){aux_off[D_W-1]}}, aux_off};
                b_op = {gain_aux[FIX_W-1], gain_aux};
            end
            MS_SEP:
            begin
                a_op = -{{(A_W-SUM_W){sep_sel[SUM_W-1]}}, sep_sel};
                b_op = {gains.sep[FIX_W-1], gains.sep};
            end
            MS_COH:
            begin
                a_op = {mean_reg[MEAN_W-1], mean_reg}
                     - {{(A_W-FIX_W){self_sel[FIX_W-1]}}, self_sel};
                b_op = {gains.coh[FIX_W-1], gains.coh};
            end
            MS_ALI:
            begin
                a_op = {mean_reg[MEAN_W-1], mean_reg};
                b_op = {gains.ali[FIX_W-1], gains.ali};
            end
            default:
            begin
                a_op = '0;
                b_op = '0;
            end
        endcase

        // operand A goes through in two slices: unsigned low, signed high
        if (cmd.mul_hi)
            part = $signed({a_op[A_W-1], a_op[A_W-1:LO_W]});
        else
            part = $signed({1'b0, a_op[LO_W-1:0]});
        pp = part * $signed(b_op);

        if (cmd.mul_hi)
            prod_next = prod_reg + {pp[PROD_W-LO_W-1:0], {LO_W{1'b0}}};
        else
            prod_next = {{(PROD_W-PP_W){pp[PP_W-1]}}, pp};

        mean_abs = sum_mean[SUM_W-1] ? -{sum_mean[SUM_W-1], sum_mean}
                                     : {sum_mean[SUM_W-1], sum_mean};
        d_abs    = d_sel[D_W-1] ? -d_sel : d_sel;
        if (cmd.div_mean)
        begin
            div_dividend = NUM_W'(mean_abs[SUM_W-1:0]);
            div_divisor  = SQ_W'(count_reg);
        end
        else
        begin
            div_dividend = {d_abs[FIX_W-1:0], {FIX_W{1'b0}}};
            div_divisor  = s_reg;
        end

        sep_val  = d_sel[D_W-1] ? -MEAN_W'(quot[D_W-1:0]) : MEAN_W'(quot[D_W-1:0]);
        mean_val = sum_mean[SUM_W-1] ? -{1'b0, quot} : {1'b0, quot};
        cnt_lt_max = (count_reg < CW'(MAX_NEIGHBOURS));
    end

    fsf_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .mean_mode (cmd.div_mean),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .done      (div_done),
        .quot      (quot)
    );

    // agent state and accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                self_reg[i] <= '0;
                goal_reg[i] <= '0;
                sep_reg[i]  <= '0;
                ali_reg[i]  <= '0;
                coh_reg[i]  <= '0;
            end
            mode_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (cmd.load)
        begin
            if (!in_kind)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    self_reg[i] <= in_pos[i];
                    goal_reg[i] <= in_aux[i];
                    sep_reg[i]  <= '0;
                    ali_reg[i]  <= '0;
                    coh_reg[i]  <= '0;
                end
                mode_reg  <= in_leader;
                count_reg <= '0;
            end
            else if (cnt_lt_max)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ali_reg[i] <= sat40({{2{ali_reg[i][SUM_W-1]}}, ali_reg[i]}
                        + {{(SUM_W+2-FIX_W){in_aux[i][FIX_W-1]}}, in_aux[i]});
                    coh_reg[i] <= sat40({{2{coh_reg[i][SUM_W-1]}}, coh_reg[i]}
                        + {{(SUM_W+2-FIX_W){in_pos[i][FIX_W-1]}}, in_pos[i]});
                end
                count_reg <= count_reg + CW'(1);
            end
        end
        else if (cmd.sep_acc)
        begin
            sep_reg[cmd.ax] <= sat40({{2{sep_sel[SUM_W-1]}}, sep_sel}
                                     + {sep_val[MEAN_W-1], sep_val});
        end
        else if (cmd.out_load)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sep_reg[i] <= '0;
                ali_reg[i] <= '0;
                coh_reg[i] <= '0;
            end
            count_reg <= '0;
        end
    end

    // working registers and result register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < 3; i++)
                d_reg[i] <= {in_pos[i][FIX_W-1], in_pos[i]}
                          - {self_reg[i][FIX_W-1], self_reg[i]};
            s_reg     <= '0;
            total_reg <= '0;
        end
        if (cmd.mul_lo || cmd.mul_hi)
            prod_reg <= prod_next;
        if (cmd.sq_acc)
            s_reg <= s_reg + prod_reg[SQ_W-1:0];
        if (cmd.term_acc)
            total_reg <= total_reg
                + {{(TOT_W-PROD_W+FRAC_W){prod_reg[PROD_W-1]}}, prod_reg[PROD_W-1:FRAC_W]};
        if (cmd.mean_set)
            mean_reg <= mean_val;
        if (cmd.force_store)
        begin
            force_reg[cmd.ax] <= sat32(total_reg);
            total_reg         <= '0;
        end
        if (cmd.out_load)
        begin
            for (int i = 0; i < 3; i++)
                out_force_reg[i] <= force_reg[i];
            out_count_reg <= CNT_OUT_W'(count_reg);
        end
    end

    assign status.cnt_lt_max = cnt_lt_max;
    assign status.cnt_zero   = (count_reg == '0);
    assign status.s_zero     = (s_reg == '0);
    assign status.div_done   = div_done && !div_busy;
    assign out_force         = out_force_reg;
    assign out_count         = out_count_reg;

endmodule

// ===== hdl/fsf_ctrl.sv =====
// ---------------------------------------------------------------------------
// Flocking steering force controller
// Sequences squares, divisions and the weighted terms; owns both handshakes.
// ---------------------------------------------------------------------------
`include "flocking_steering_force_core_macros.svh"

module fsf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              in_kind,
    input  logic              in_last,
    input  logic              m_tready,
    input  fsf_pkg::status_t  status,
    output logic              s_tready,
    output logic              m_tvalid,
    output fsf_pkg::cmd_t     cmd
);
    import fsf_pkg::*;

    typedef enum logic [12:0] {
        ST_IDLE      = 13'b0000000000001,
        ST_SQ_LO     = 13'b0000000000010,
        ST_SQ_HI     = 13'b0000000000100,
        ST_SQ_ACC    = 13'b0000000001000,
        ST_DIV_GO    = 13'b0000000010000,
        ST_DIV_WAIT  = 13'b0000000100000,
        ST_MUL_LO    = 13'b0000001000000,
        ST_MUL_HI    = 13'b0000010000000,
        ST_TERM_ACC  = 13'b0000100000000,
        ST_MEAN_GO   = 13'b0001000000000,
        ST_MEAN_WAIT = 13'b0010000000000,
        ST_SAT       = 13'b0100000000000,
        ST_OUT       = 13'b1000000000000
    } state_t;

    state_t      state_reg, state_next;
    logic [1:0]  ax_reg, ax_next;
    msel_t       term_reg, term_next;
    logic        last_reg, last_next;
    logic        out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        ax_next        = ax_reg;
        term_next      = term_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.msel       = term_reg;
        cmd.ax         = ax_reg;
        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load  = 1'b1;
                    last_next = in_last;
                    ax_next   = 2'd0;
                    term_next = MS_AUX;
                    if (in_kind && status.cnt_lt_max)
                        state_next = ST_SQ_LO;
                    else if (in_last)
                        state_next = ST_MUL_LO;
                end
            end
            ST_SQ_LO:
            begin
                cmd.msel   = MS_SQ;
                cmd.mul_lo = 1'b1;
                state_next = ST_SQ_HI;
            end
            ST_SQ_HI:
            begin
                cmd.msel   = MS_SQ;
                cmd.mul_hi = 1'b1;
                state_next = ST_SQ_ACC;
            end
            ST_SQ_ACC:
            begin
                cmd.sq_acc = 1'b1;
                if (ax_reg == 2'd2)
                begin
                    ax_next    = 2'd0;
                    state_next = ST_DIV_GO;
                end
                else
                begin
                    ax_next    = ax_reg + 2'd1;
                    state_next = ST_SQ_LO;
                end
            end
            ST_DIV_GO:
            begin
                // coincident neighbour: skip separation altogether
                if (status.s_zero)
                begin
                    ax_next    = 2'd0;
                    state_next = last_reg ? ST_MUL_LO : ST_IDLE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.sep_acc = 1'b1;
                    if (ax_reg == 2'd2)
                    begin
                        ax_next    = 2'd0;
                        state_next = last_reg ? ST_MUL_LO : ST_IDLE;
                    end
                    else
                    begin
                        ax_next    = ax_reg + 2'd1;
                        state_next = ST_DIV_GO;
                    end
                end
            end
            ST_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = ST_TERM_ACC;
            end
            ST_TERM_ACC:
            begin
                cmd.term_acc = 1'b1;
                case (term_reg)
                    MS_AUX:
                    begin
                        if (status.cnt_zero)
                            state_next = ST_SAT;
                        else
                        begin
                            term_next  = MS_SEP;
                            state_next = ST_MUL_LO;
                        end
                    end
                    MS_SEP:
                    begin
                        term_next  = MS_COH;
                        state_next = ST_MEAN_GO;
                    end
                    MS_COH:
                    begin
                        term_next  = MS_ALI;
                        state_next = ST_MEAN_GO;
                    end
                    default:
                        state_next = ST_SAT;
                endcase
            end
            ST_MEAN_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_mean  = 1'b1;
                state_next    = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT:
            begin
                cmd.div_mean = 1'b1;
                if (status.div_done)
                begin
                    cmd.mean_set = 1'b1;
                    state_next   = ST_MUL_LO;
                end
            end
            ST_SAT:
            begin
                cmd.force_store = 1'b1;
                term_next       = MS_AUX;
                if (ax_reg == 2'd2)
                    state_next = ST_OUT;
                else
                begin
                    ax_next    = ax_reg + 2'd1;
                    state_next = ST_MUL_LO;
                end
            end
            ST_OUT:
            begin
                // hold until the result register is free
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ax_reg        <= 2'd0;
            term_reg      <= MS_AUX;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ax_reg        <= ax_next;
            term_reg      <= term_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    `FSF_ASSERT_NEXT(a_self_only_back_idle, clk, rst_n, state_reg == ST_IDLE && s_tvalid && !in_kind && !in_last, state_reg == ST_IDLE)
    `FSF_ASSERT_IMP(a_axis_in_range, clk, rst_n, state_reg != ST_IDLE, ax_reg != 2'd3)
    `FSF_ASSERT_NEXT(a_out_load_shows, clk, rst_n, state_reg == ST_OUT && (!out_valid_reg || m_tready), m_tvalid && state_reg == ST_IDLE)

endmodule

// ===== hdl/flocking_steering_force_core.sv =====
// ---------------------------------------------------------------------------
// Flocking steering force core
// Accumulates neighbour records against a self record and returns the
// weighted, saturated Q16.16 steering force when a group closes.
// ---------------------------------------------------------------------------
//  channel   dir  signals                         contents
//  s_*       in   s_tvalid/s_tready/s_tdata/      positions and aux, kind,
//                 s_tuser/s_tlast                 follows_leader, last
//  m_*       out  m_tvalid/m_tready/m_tdata       force x/y/z, neighbour count
//  APB       in   psel/penable/pwrite/paddr/...   five Q16.16 gains
//
//  A neighbour record squares its offset on each axis, then divides the
//  separation of each axis on the one-bit-per-cycle divider; a coincident
//  one skips the divisions. Closing a group takes, per axis, only the goal
//  or follow term with no neighbours, else two 40-bit mean divisions and
//  four two-slice multiplies; the result register is loaded last. A self
//  record without last goes straight back to idle. Reset is asynchronous
//  and sets all gains to 1.0. A stalled result sits in the output register
//  while the next items are taken; only the next result waits for it.
// ---------------------------------------------------------------------------
module flocking_steering_force_core #(
    parameter int MAX_NEIGHBOURS = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,   // pos_x, pos_y, pos_z, aux_x, aux_y, aux_z
    input  logic [1:0]   s_tuser,   // kind, follows_leader
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // force_x, force_y, force_z, neighbour_count, pad
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import fsf_pkg::*;

    gains_t                 gains_reg;
    logic [2:0]             reg_idx;
    logic                   wr_en;
    cmd_t                   cmd;
    status_t                status;
    logic [2:0][FIX_W-1:0]  in_pos;
    logic [2:0][FIX_W-1:0]  in_aux;
    logic [2:0][FIX_W-1:0]  out_force;
    logic [CNT_OUT_W-1:0]   out_count;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg.sep  <= 32'h0001_0000;
            gains_reg.coh  <= 32'h0001_0000;
            gains_reg.ali  <= 32'h0001_0000;
            gains_reg.fol  <= 32'h0001_0000;
            gains_reg.goal <= 32'h0001_0000;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_SEP_GAIN:    gains_reg.sep  <= pwdata;
                REG_COH_GAIN:    gains_reg.coh  <= pwdata;
                REG_ALI_GAIN:    gains_reg.ali  <= pwdata;
                REG_FOLLOW_GAIN: gains_reg.fol  <= pwdata;
                REG_GOAL_GAIN:   gains_reg.goal <= pwdata;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_SEP_GAIN:    prdata = gains_reg.sep;
            REG_COH_GAIN:    prdata = gains_reg.coh;
            REG_ALI_GAIN:    prdata = gains_reg.ali;
            REG_FOLLOW_GAIN: prdata = gains_reg.fol;
            REG_GOAL_GAIN:   prdata = gains_reg.goal;
            default:         prdata = '0;
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            in_pos[i] = s_tdata[i*FIX_W +: FIX_W];
            in_aux[i] = s_tdata[(i+3)*FIX_W +: FIX_W];
        end
    end

    fsf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .in_kind  (s_tuser[0]),
        .in_last  (s_tlast),
        .m_tready (m_tready),
        .status   (status),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    fsf_dp #(
        .MAX_NEIGHBOURS (MAX_NEIGHBOURS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .gains     (gains_reg),
        .in_kind   (s_tuser[0]),
        .in_leader (s_tuser[1]),
        .in_pos    (in_pos),
        .in_aux    (in_aux),
        .status    (status),
        .out_force (out_force),
        .out_count (out_count)
    );

    assign m_tdata = {1'b0, out_count, out_force[2], out_force[1], out_force[0]};

endmodule

// ===== sim/flocking_steering_force_core_test.sv =====
// ---------------------------------------------------------------------------
// Flocking steering force core testbench
// Drives self and neighbour records over the input stream, programs the gains
// over APB between phases, and checks every force result against a local
// fixed-point prediction of the steering sum.
// ---------------------------------------------------------------------------
module flocking_steering_force_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import fsf_pkg::*;

    localparam int NB_MAX = 64;
    localparam int WATCH_LIMIT = 200000;

    typedef struct {
        logic             kind;
        logic signed [31:0] pos [3];
        logic signed [31:0] aux [3];
        logic             leader;
        logic             last;
    } record_t;

    typedef struct packed {
        logic [6:0]  cnt;
        logic [31:0] fz;
        logic [31:0] fy;
        logic [31:0] fx;
    } force_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    // predictor state
    logic signed [31:0] gain [5];
    logic signed [63:0] self_pos [3];
    logic signed [63:0] goal_pos [3];
    logic               lead_mode;
    logic signed [63:0] sep_acc [3];
    logic signed [63:0] ali_acc [3];
    logic signed [63:0] coh_acc [3];
    int                 nb_count;

    force_t expected_forces [$];
    int     errors;
    int     idle_cycles;
    bit     stall_sink;

    flocking_steering_force_core #(.MAX_NEIGHBOURS(NB_MAX)) dut (.*);

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic logic signed [63:0] sat_acc(input logic signed [63:0] v);
        logic signed [63:0] hi;
        hi = (64'sd1 <<< 39) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    // floor(v * g / 2^16), exact in 128 bits
    function automatic logic signed [127:0] gain_mul(input logic signed [63:0] v,
                                                     input logic signed [31:0] g);
        logic signed [127:0] p;
        p = 128'(v) * 128'(g);
        return p >>> 16;
    endfunction

    // d * 2^32 / s, truncated toward zero
    function automatic logic signed [63:0] sep_quot(input logic signed [63:0] d,
                                                    input logic [127:0] s);
        logic [127:0] mag;
        logic [127:0] q;
        mag = (d < 0) ? 128'(-d) : 128'(d);
        q = (mag << 32) / s;
        return (d < 0) ? -$signed(64'(q)) : $signed(64'(q));
    endfunction

    function automatic void clear_acc();
        for (int i = 0; i < 3; i++)
        begin
            sep_acc[i] = 0;
            ali_acc[i] = 0;
            coh_acc[i] = 0;
        end
        nb_count = 0;
    endfunction

    function automatic void predict_force(input record_t r);
        logic signed [63:0] d [3];
        logic [127:0] s;
        logic signed [127:0] total;
        force_t f;
        if (!r.kind)
        begin
            for (int i = 0; i < 3; i++)
            begin
                self_pos[i] = r.pos[i];
                goal_pos[i] = r.aux[i];
            end
            lead_mode = r.leader;
            clear_acc();
        end
        else if (nb_count < NB_MAX)
        begin
            s = 0;
            for (int i = 0; i < 3; i++)
            begin
                d[i] = 64'(r.pos[i]) - self_pos[i];
                // square in 128 bits: a full 33-bit offset overflows 64
                s += 128'(d[i]) * 128'(d[i]);
            end
            for (int i = 0; i < 3; i++)
            begin
                if (s != 0)
                    sep_acc[i] = sat_acc(sep_acc[i] + sep_quot(d[i], s));
                ali_acc[i] = sat_acc(ali_acc[i] + 64'(r.aux[i]));
                coh_acc[i] = sat_acc(coh_acc[i] + 64'(r.pos[i]));
            end
            nb_count++;
        end
        if (!r.last)
            return;
        for (int i = 0; i < 3; i++)
        begin
            total = gain_mul(goal_pos[i] - self_pos[i],
                             lead_mode ? gain[REG_FOLLOW_GAIN] : gain[REG_GOAL_GAIN]);
            if (nb_count > 0)
            begin
                total += gain_mul(-sep_acc[i], gain[REG_SEP_GAIN]);
                total += gain_mul(coh_acc[i] / nb_count - self_pos[i], gain[REG_COH_GAIN]);
                total += gain_mul(ali_acc[i] / nb_count, gain[REG_ALI_GAIN]);
            end
            if (total > 128'sd2147483647)
                total = 128'sd2147483647;
            if (total < -128'sd2147483648)
                total = -128'sd2147483648;
            case (i)
                0: f.fx = total[31:0];
                1: f.fy = total[31:0];
                default: f.fz = total[31:0];
            endcase
        end
        f.cnt = 7'(nb_count);
        expected_forces.insert(expected_forces.size(), f);
        clear_acc();
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40)
            return 0;
        if (p < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // valid stays high into the next record when there is no gap
    task automatic send_record(input record_t r);
        int n;
        n = gap_len();
        if (n != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {r.aux[2], r.aux[1], r.aux[0], r.pos[2], r.pos[1], r.pos[0]};
        s_tuser <= {r.leader, r.kind};
        s_tlast <= r.last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_force(r);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_forces.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    task automatic write_gain(input logic [2:0] idx, input logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(idx) << 2;
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        gain[idx] = v;
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h7fffffff;
            2: return 32'h80000000;
            default: return $signed($urandom_range(0, 2000000)) - 1000000;
        endcase
    endfunction

    function automatic record_t make_record(input logic kind, input logic last);
        record_t r;
        r.kind = kind;
        r.last = last;
        r.leader = 1'($urandom_range(0, 1));
        for (int i = 0; i < 3; i++)
        begin
            r.pos[i] = rand_coord();
            r.aux[i] = rand_coord();
        end
        return r;
    endfunction

    task automatic test_directed();
        record_t r;
        // self with no neighbours, goal then leader
        r = make_record(1'b0, 1'b1);
        r.leader = 1'b0;
        send_record(r);
        r.leader = 1'b1;
        send_record(r);
        // neighbours against the stored self
        send_record(make_record(1'b1, 1'b0));
        send_record(make_record(1'b1, 1'b1));
        // extremes and a coincident neighbour
        r = make_record(1'b0, 1'b0);
        for (int i = 0; i < 3; i++)
        begin
            r.pos[i] = 32'h80000000;
            r.aux[i] = 32'h7fffffff;
        end
        send_record(r);
        r.kind = 1'b1;
        send_record(r);
        for (int i = 0; i < 3; i++)
        begin
            r.pos[i] = 32'h7fffffff;
            r.aux[i] = 32'h80000000;
        end
        send_record(r);
        r.leader = 1'b1;
        r.last = 1'b1;
        send_record(r);
        r = make_record(1'b0, 1'b0);
        send_record(r);
        r.kind = 1'b1;
        r.last = 1'b1;
        send_record(r);
    endtask

    task automatic test_overflow_group();
        // more neighbours than the limit, the last one closes the group
        send_record(make_record(1'b0, 1'b0));
        for (int k = 0; k < NB_MAX + 3; k++)
            send_record(make_record(1'b1, k == NB_MAX + 2));
    endtask

    task automatic test_random(input int n_items);
        int sent;
        int len;
        record_t r;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                r = make_record(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                send_record(r);
                sent++;
            end
            else
            begin
                len = $urandom_range(0, 6);
                send_record(make_record(1'b0, len == 0));
                sent++;
                for (int k = 0; k < len; k++)
                begin
                    send_record(make_record(1'b1, k == len - 1));
                    sent++;
                end
            end
        end
    endtask

    task automatic program_gains(input int mode);
        logic [31:0] v;
        for (int i = REG_SEP_GAIN; i <= REG_GOAL_GAIN; i++)
        begin
            case (mode)
                0: v = 32'h7fffffff;
                1: v = 32'h80000000;
                2: v = 32'h00000000;
                default: v = $urandom();
            endcase
            write_gain(3'(i), v);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        force_t got;
        force_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[102:0];
            if (expected_forces.size() == 0)
            begin
                $display("%0t unexpected result: expected none actual %h", $time, got);
                errors++;
            end
            else
            begin
                want = expected_forces.pop_front();
                if (got.fx !== want.fx)
                begin
                    $display("%0t force_x: expected %h actual %h", $time, want.fx, got.fx);
                    errors++;
                end
                if (got.fy !== want.fy)
                begin
                    $display("%0t force_y: expected %h actual %h", $time, want.fy, got.fy);
                    errors++;
                end
                if (got.fz !== want.fz)
                begin
                    $display("%0t force_z: expected %h actual %h", $time, want.fz, got.fz);
                    errors++;
                end
                if (got.cnt !== want.cnt)
                begin
                    $display("%0t neighbour_count: expected %0d actual %0d",
                             $time, want.cnt, got.cnt);
                    errors++;
                end
            end
        end
    end

    // receiver stalls of random length, with some stretches never stalling
    always @(posedge clk)
    begin
        int p;
        int stall_left;
        p = $urandom_range(0, 99);
        if (!rst_n)
        begin
            stall_left = 0;
            m_tready <= 1'b0;
        end
        else if (!stall_sink)
            m_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (p < 30)
        begin
            stall_left = gap_len();
            m_tready <= (stall_left == 0);
            if (stall_left > 0)
                stall_left--;
        end
        else
            m_tready <= 1'b1;
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        s_tlast = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        stall_sink = 1'b1;
        for (int i = 0; i < 5; i++)
            gain[i] = 32'sd65536;
        for (int i = 0; i < 3; i++)
        begin
            self_pos[i] = 0;
            goal_pos[i] = 0;
        end
        lead_mode = 1'b0;
        clear_acc();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_overflow_group();
        drain();
        for (int mode = 0; mode < 4; mode++)
        begin
            program_gains(mode);
            stall_sink = (mode != 2);
            test_random(mode == 3 ? 700 : 100);
            drain();
        end
        write_gain(REG_SEP_GAIN, 32'sd65536);
        test_random(60);
        drain();

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
